/* src/i2cmts_pkg.sv */
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Shared types and constants for the i2c master transfer sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmts_pkg;

  // message store geometry
  localparam int BUFFER_DEPTH = 32;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  // result queue geometry
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  // item modes
  typedef enum logic [2:0] {
    MODE_LOAD   = 3'd0,
    MODE_WRITE  = 3'd1,
    MODE_READ   = 3'd2,
    MODE_EVENT  = 3'd3,
    MODE_RDBYTE = 3'd4
  } mode_t;

  // bus actions
  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_RX_ACK  = 3'd3,
    ACT_RX_NACK = 3'd4,
    ACT_STOP    = 3'd5,
    ACT_ABORT   = 3'd6
  } action_t;

  // bus engine status codes
  localparam logic [7:0] ST_START         = 8'h08;
  localparam logic [7:0] ST_RESTART       = 8'h10;
  localparam logic [7:0] ST_MT_ADDR_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_ADDR_NACK  = 8'h20;
  localparam logic [7:0] ST_MT_DATA_ACK   = 8'h28;
  localparam logic [7:0] ST_MT_DATA_NACK  = 8'h30;
  localparam logic [7:0] ST_ARB_LOST      = 8'h38;
  localparam logic [7:0] ST_MR_ADDR_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_ADDR_NACK  = 8'h48;
  localparam logic [7:0] ST_MR_DATA_ACK   = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK  = 8'h58;
  localparam logic [7:0] ST_BUS_ERROR     = 8'h00;

  // one accepted input item
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] slave_address;
    logic [5:0] length;
    logic [4:0] buffer_index;
    logic [7:0] data_byte;
    logic [7:0] status_code;
    logic [7:0] bus_byte_in;
  } item_t;

  // message store access for one item
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } mem_req_t;

  // decision waiting for the store read data
  typedef struct packed {
    action_t    action;
    logic       tx_from_mem;
    logic [7:0] tx_byte;
    logic       busy;
    logic       ok;
    logic [5:0] count;
    logic       rd_from_mem;
    logic       rejected;
  } stage_t;

  // finished result
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] bus_byte_out;
    logic       busy_res;
    logic       transfer_ok;
    logic [5:0] byte_count;
    logic [7:0] read_byte;
    logic       rejected;
  } result_t;

endpackage

`default_nettype wire

/* src/i2cmts_if.sv */
// ----------------------------------------------------------------------------
// i2cmts channel interfaces
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cmts_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] slave_address;
  logic [5:0] length;
  logic [4:0] buffer_index;
  logic [7:0] data_byte;
  logic [7:0] status_code;
  logic [7:0] bus_byte_in;

  modport source (
    output valid, mode, slave_address, length, buffer_index, data_byte,
           status_code, bus_byte_in,
    input  ready
  );
  modport sink (
    input  valid, mode, slave_address, length, buffer_index, data_byte,
           status_code, bus_byte_in,
    output ready
  );
endinterface

interface i2cmts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] bus_byte_out;
  logic       busy_res;
  logic       transfer_ok;
  logic [5:0] byte_count;
  logic [7:0] read_byte;
  logic       rejected;

  modport source (
    output valid, action, bus_byte_out, busy_res, transfer_ok, byte_count,
           read_byte, rejected,
    input  ready
  );
  modport sink (
    input  valid, action, bus_byte_out, busy_res, transfer_ok, byte_count,
           read_byte, rejected,
    output ready
  );
endinterface

`default_nettype wire

/* src/i2c_master_transfer_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Sequences one i2c master transfer over a byte-level bus engine.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  in_ch     sink       valid/ready    mode, address, length, index, bytes, status
//  out_ch    source     valid/ready    action, tx byte, busy, ok, count, read byte
//
//  one item accepted per cycle while in_ch is ready; its decision waits in a
//  register for the message store read (one read port, registered data)
//  up to three results wait when out_ch stalls; in_ch stays ready below that
//  synchronous reset clears the transfer state and the result queue only;
//  the message store is not cleared and holds garbage until loaded
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  i2cmts_in_if.sink     in_ch,
  i2cmts_out_if.source  out_ch
);

  item_t                 item;
  logic                  accept;
  mem_req_t              mem_req;
  stage_t                dec;
  stage_t                s1_r;
  logic                  s1_valid_r;
  logic [7:0]            rdata;
  logic [OQ_CNT_W-1:0]   oq_cnt;

  // input item
  assign item.mode          = in_ch.mode;
  assign item.slave_address = in_ch.slave_address;
  assign item.length        = in_ch.length;
  assign item.buffer_index  = in_ch.buffer_index;
  assign item.data_byte     = in_ch.data_byte;
  assign item.status_code   = in_ch.status_code;
  assign item.bus_byte_in   = in_ch.bus_byte_in;

  // ready while the queue keeps a slot for the item in flight
  assign in_ch.ready = ((OQ_CNT_W + 1)'(oq_cnt) + (OQ_CNT_W + 1)'(s1_valid_r))
                       <= (OQ_CNT_W + 1)'(OQ_DEPTH - 2);
  assign accept      = in_ch.valid && in_ch.ready;

  i2cmts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (item),
    .mem_req (mem_req),
    .dec     (dec)
  );

  i2cmts_msg_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rdata_r (rdata)
  );

  // decision waits in a register for the store read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= dec;
    end
  end

  i2cmts_out_queue u_out_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (s1_valid_r),
    .stage  (s1_r),
    .rdata  (rdata),
    .cnt_r  (oq_cnt),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

/* src/i2cmts_msg_ram.sv */
// ----------------------------------------------------------------------------
// i2cmts_msg_ram
// Message store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmts_msg_ram
  import i2cmts_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output logic [7:0]    rdata_r
);

  logic [7:0] mem [BUFFER_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/i2cmts_ctrl.sv */
// ----------------------------------------------------------------------------
// i2cmts_ctrl
// Transfer state and per-item decision; issues the message store access.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmts_ctrl
  import i2cmts_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  accept,
  input  wire item_t item,
  output mem_req_t   mem_req,
  output stage_t     dec
);

  logic [7:0] addr_r, addr_nxt;
  logic [5:0] len_r, len_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic       ok_r, ok_nxt;
  logic       busy_r, busy_nxt;

  logic       room;
  logic       idx_ok;
  logic [5:0] pos_plus;
  logic [5:0] len_clamp;

  // store has space at the current position
  assign room      = (pos_r < len_r) && (32'(pos_r) < BUFFER_DEPTH);
  assign idx_ok    = 32'(item.buffer_index) < BUFFER_DEPTH;
  assign pos_plus  = pos_r + 6'd1;
  assign len_clamp = (32'(item.length) > BUFFER_DEPTH) ? 6'(BUFFER_DEPTH) : item.length;

  // decision for the item at the port
  always_comb begin
    addr_nxt    = addr_r;
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    ok_nxt      = ok_r;
    busy_nxt    = busy_r;
    mem_req     = '0;
    dec         = '0;
    dec.action  = ACT_NONE;

    case (mode_t'(item.mode))
      MODE_LOAD: begin
        if (busy_r) begin
          dec.rejected = 1'b1;
        end else if (idx_ok) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = ADDR_W'(item.buffer_index);
          mem_req.wr_data = item.data_byte;
        end
      end
      MODE_WRITE, MODE_READ: begin
        if (busy_r) begin
          dec.rejected = 1'b1;
        end else begin
          addr_nxt   = (mode_t'(item.mode) == MODE_WRITE) ?
                       {item.slave_address[7:1], 1'b0} :
                       {item.slave_address[7:1], 1'b1};
          len_nxt    = len_clamp;
          pos_nxt    = '0;
          ok_nxt     = 1'b0;
          busy_nxt   = 1'b1;
          dec.action = ACT_START;
        end
      end
      MODE_EVENT: begin
        if (busy_r) begin
          case (item.status_code)
            ST_START, ST_RESTART: begin
              pos_nxt     = '0;
              dec.tx_byte = addr_r;
              dec.action  = ACT_SEND;
            end
            ST_ARB_LOST: begin
              dec.action = ACT_START;
            end
            ST_MT_ADDR_ACK, ST_MT_DATA_ACK: begin
              if (room) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ADDR_W'(pos_r);
                dec.tx_from_mem = 1'b1;
                pos_nxt         = pos_plus[5:0];
                dec.action      = ACT_SEND;
              end else begin
                ok_nxt     = 1'b1;
                busy_nxt   = 1'b0;
                dec.action = ACT_STOP;
              end
            end
            ST_MR_ADDR_ACK: begin
              dec.action = (len_r > 6'd1) ? ACT_RX_ACK : ACT_RX_NACK;
            end
            ST_MR_DATA_ACK: begin
              if (room) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ADDR_W'(pos_r);
                mem_req.wr_data = item.bus_byte_in;
                pos_nxt         = pos_plus[5:0];
              end
              // ack while another byte still fits after this one
              dec.action = (({1'b0, pos_nxt} + 7'd1) < {1'b0, len_r}) ?
                           ACT_RX_ACK : ACT_RX_NACK;
            end
            ST_MR_DATA_NACK: begin
              if (room) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = ADDR_W'(pos_r);
                mem_req.wr_data = item.bus_byte_in;
                pos_nxt         = pos_plus[5:0];
              end
              len_nxt    = pos_nxt;
              ok_nxt     = 1'b1;
              busy_nxt   = 1'b0;
              dec.action = ACT_STOP;
            end
            default: begin
              // nack, bus error or unknown code
              len_nxt    = pos_r;
              busy_nxt   = 1'b0;
              dec.action = ACT_ABORT;
            end
          endcase
        end
      end
      MODE_RDBYTE: begin
        if (idx_ok) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_W'(item.buffer_index);
          dec.rd_from_mem = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // nothing happens without a transfer
    if (!accept) begin
      mem_req = '0;
    end

    dec.busy  = busy_nxt;
    dec.ok    = ok_nxt;
    dec.count = pos_nxt;
  end

  // transfer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      len_r  <= '0;
      pos_r  <= '0;
      ok_r   <= 1'b0;
      busy_r <= 1'b0;
    end else if (accept) begin
      addr_r <= addr_nxt;
      len_r  <= len_nxt;
      pos_r  <= pos_nxt;
      ok_r   <= ok_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/i2cmts_out_queue.sv */
// ----------------------------------------------------------------------------
// i2cmts_out_queue
// Merges store read data into the decision and buffers finished results.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmts_out_queue
  import i2cmts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire stage_t      stage,
  input  wire logic [7:0]  rdata,
  output logic [OQ_CNT_W-1:0] cnt_r,
  i2cmts_out_if.source     out_ch
);

  result_t               q_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [OQ_CNT_W-1:0]   cnt_nxt;
  logic                  pop;
  result_t               res;
  result_t               head;

  // finished result from decision and read data
  always_comb begin
    res.action       = stage.action;
    res.bus_byte_out = stage.tx_from_mem ? rdata : stage.tx_byte;
    res.busy_res     = stage.busy;
    res.transfer_ok  = stage.ok;
    res.byte_count   = stage.count;
    res.read_byte    = stage.rd_from_mem ? rdata : 8'h00;
    res.rejected     = stage.rejected;
  end

  assign pop     = out_ch.valid && out_ch.ready;
  assign cnt_nxt = cnt_r + OQ_CNT_W'(push) - OQ_CNT_W'(pop);

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= res;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // head of queue to the port
  assign head                = q_r[rd_ptr_r];
  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.action       = head.action;
  assign out_ch.bus_byte_out = head.bus_byte_out;
  assign out_ch.busy_res     = head.busy_res;
  assign out_ch.transfer_ok  = head.transfer_ok;
  assign out_ch.byte_count   = head.byte_count;
  assign out_ch.read_byte    = head.read_byte;
  assign out_ch.rejected     = head.rejected;

endmodule

`default_nettype wire
